// ----- hw/rtl/nfbhp_pkg.sv -----
`timescale 1ns / 1ps

package nfbhp_pkg;

    // Field format codes carried by the first byte of a field.
    localparam logic [2:0] FMT_COPY  = 3'd0;
    localparam logic [2:0] FMT_LBCD  = 3'd1;
    localparam logic [2:0] FMT_RBCD  = 3'd2;
    localparam logic [2:0] FMT_HEX   = 3'd3;
    localparam logic [2:0] FMT_ELBCD = 3'd4;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_FMT  = 2'd1;
    localparam logic [1:0] ST_NO_FIELD = 2'd2;

    // Field state that does not depend on the digit count width.
    typedef struct packed {
        logic [2:0] fmt;
        logic       active;
        logic       drop;
        logic       pair;
        logic [7:0] held;
    } t_flags;

    // One result transfer.
    typedef struct packed {
        logic [7:0] data;
        logic [1:0] status;
        logic       field_end;
        logic       item_last;
    } t_result;

    function automatic logic is_digit(input logic [7:0] c);
        is_digit = (c >= 8'h30) && (c <= 8'h39);
    endfunction

    // Nibble to character: digits map to '0'..'9', larger values to 'A'..'F'.
    function automatic logic [7:0] nib_char(input logic [3:0] n);
        if (n <= 4'd9) begin
            nib_char = {4'h3, n};
        end else begin
            nib_char = 8'h37 + {4'h0, n};
        end
    endfunction

endpackage

// ----- hw/rtl/nfbhp_core.sv -----
`timescale 1ns / 1ps

module nfbhp_core #(
    parameter int DIGIT_COUNT_BITS = 10
) (
    input  logic                        i_direction,
    input  logic [7:0]                  i_byte,
    input  logic                        i_start,
    input  logic [2:0]                  i_format,
    input  logic [DIGIT_COUNT_BITS-1:0] i_digits,
    input  logic [DIGIT_COUNT_BITS-1:0] i_chars,
    input  logic [DIGIT_COUNT_BITS-1:0] i_bytes,
    input  nfbhp_pkg::t_flags           i_flags,
    output logic [DIGIT_COUNT_BITS-1:0] o_chars,
    output logic [DIGIT_COUNT_BITS-1:0] o_bytes,
    output nfbhp_pkg::t_flags           o_flags,
    output logic [1:0]                  o_count,
    output nfbhp_pkg::t_result          o_res0,
    output nfbhp_pkg::t_result          o_res1
);
    import nfbhp_pkg::*;

    localparam int W = DIGIT_COUNT_BITS;

    logic [W-1:0] s_chars;
    logic [W-1:0] s_bytes;
    t_flags       s_flags;
    logic         s_bad;
    logic [W:0]   s_half_up;

    logic [7:0]   hx_a;
    logic [7:0]   hx_b;
    logic [7:0]   hx_byte;

    logic [7:0]   pk_res;
    logic         pk_emit;
    logic [7:0]   up_c0;
    logic [7:0]   up_c1;
    logic         up_two;
    logic         fe;

    assign s_half_up = ({1'b0, i_digits} + {{W{1'b0}}, 1'b1}) >> 1;

    // Field opening: a start byte resets the field and loads the new format; an invalid format marks the field to drop.
    always_comb begin
        s_flags = i_flags;
        s_chars = i_chars;
        s_bytes = i_bytes;
        s_bad   = 1'b0;
        if (i_start) begin
            s_flags.active = 1'b0;
            s_flags.pair   = 1'b0;
            s_flags.held   = 8'h00;
            s_flags.drop   = 1'b0;
            s_chars        = '0;
            s_bytes        = '0;
            if (i_format > FMT_ELBCD) begin
                s_flags.drop = 1'b1;
                s_bad        = 1'b1;
            end else begin
                s_flags.fmt = i_format;
                s_chars     = i_digits;
                if (i_format == FMT_COPY) begin
                    s_bytes = i_digits;
                end else if (i_format == FMT_HEX) begin
                    s_bytes = i_digits >> 1;
                end else begin
                    s_bytes = s_half_up[W-1:0];
                end
                if ((!i_direction && s_chars != '0) || (i_direction && s_bytes != '0)) begin
                    s_flags.active = 1'b1;
                end else begin
                    s_chars = '0;
                    s_bytes = '0;
                end
            end
        end
    end

    // Hex pair packing: letters get an extra 0x90 in the high nibble, 0x09 in the low.
    assign hx_a    = {s_flags.held[3:0], 4'h0} + (is_digit(s_flags.held) ? 8'h00 : 8'h90);
    assign hx_b    = hx_a | {4'h0, i_byte[3:0]};
    assign hx_byte = hx_b + (is_digit(i_byte) ? 8'h00 : 8'h09);

    always_comb begin
        o_flags = s_flags;
        o_chars = s_chars;
        o_bytes = s_bytes;
        o_count = 2'd0;
        o_res0  = '0;
        o_res1  = '0;
        pk_res  = 8'h00;
        pk_emit = 1'b0;
        up_c0   = 8'h00;
        up_c1   = 8'h00;
        up_two  = 1'b0;
        fe      = 1'b0;
        if (s_bad) begin
            o_count = 2'd1;
            o_res0  = '{data: 8'h00, status: ST_BAD_FMT, field_end: 1'b1, item_last: 1'b1};
        end else if (!s_flags.active) begin
            if (!s_flags.drop) begin
                o_count = 2'd1;
                o_res0  = '{data: 8'h00, status: ST_NO_FIELD, field_end: 1'b0,
                            item_last: 1'b1};
            end
        end else if (!i_direction) begin
            if (s_flags.fmt == FMT_COPY) begin
                pk_res  = i_byte;
                pk_emit = 1'b1;
            end else if (!s_flags.pair) begin
                if ((s_flags.fmt == FMT_LBCD || s_flags.fmt == FMT_ELBCD)
                    && s_chars == W'(1)) begin
                    pk_res  = {i_byte[3:0], 4'hF};
                    pk_emit = 1'b1;
                end else if (s_flags.fmt == FMT_RBCD && s_chars[0]) begin
                    pk_res  = {4'h0, i_byte[3:0]};
                    pk_emit = 1'b1;
                end else if (s_flags.fmt == FMT_HEX && s_chars == W'(1)) begin
                    pk_emit = 1'b0;
                end else begin
                    o_flags.held = i_byte;
                    o_flags.pair = 1'b1;
                end
            end else begin
                pk_res       = (s_flags.fmt == FMT_HEX) ? hx_byte
                                                        : {s_flags.held[3:0], i_byte[3:0]};
                o_flags.pair = 1'b0;
                pk_emit      = 1'b1;
            end
            o_chars = s_chars - W'(1);
            if (pk_emit && s_bytes != '0) begin
                o_bytes = s_bytes - W'(1);
            end
            if (o_chars == '0) begin
                o_flags.active = 1'b0;
                o_flags.pair   = 1'b0;
            end
            if (pk_emit) begin
                o_count = 2'd1;
                o_res0  = '{data: pk_res, status: ST_OK, field_end: (o_bytes == '0),
                            item_last: 1'b1};
            end
        end else begin
            case (s_flags.fmt) inside
                FMT_COPY: begin
                    up_c0 = i_byte;
                end
                FMT_RBCD: begin
                    if (s_chars[0]) begin
                        up_c0 = {4'h3, i_byte[3:0]};
                    end else begin
                        up_c0  = {4'h3, i_byte[7:4]};
                        up_c1  = {4'h3, i_byte[3:0]};
                        up_two = 1'b1;
                    end
                end
                FMT_HEX, FMT_ELBCD: begin
                    up_c0  = nib_char(i_byte[7:4]);
                    up_c1  = nib_char(i_byte[3:0]);
                    up_two = 1'b1;
                end
                default: begin
                    up_c0  = {4'h3, i_byte[7:4]};
                    up_c1  = {4'h3, i_byte[3:0]};
                    up_two = 1'b1;
                end
            endcase
            // Never produce more characters than the field still owes.
            if (up_two && s_chars < W'(2)) begin
                up_two = 1'b0;
            end
            if (up_two) begin
                o_chars = s_chars - W'(2);
            end else if (s_chars != '0) begin
                o_chars = s_chars - W'(1);
            end
            if (s_bytes != '0) begin
                o_bytes = s_bytes - W'(1);
            end
            fe = (o_bytes == '0);
            if (fe) begin
                o_flags.active = 1'b0;
                o_chars        = '0;
            end
            if (up_two) begin
                o_count = 2'd2;
                o_res0  = '{data: up_c0, status: ST_OK, field_end: 1'b0, item_last: 1'b0};
                o_res1  = '{data: up_c1, status: ST_OK, field_end: fe, item_last: 1'b1};
            end else begin
                o_count = 2'd1;
                o_res0  = '{data: up_c0, status: ST_OK, field_end: fe, item_last: 1'b1};
            end
        end
    end

endmodule

// ----- hw/rtl/nfbhp_obuf.sv -----
`timescale 1ns / 1ps

module nfbhp_obuf (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_load,
    input  logic [1:0]          i_count,
    input  nfbhp_pkg::t_result  i_res0,
    input  nfbhp_pkg::t_result  i_res1,
    output logic                o_can_load,
    output logic                o_valid,
    input  logic                i_ready,
    output nfbhp_pkg::t_result  o_res
);
    import nfbhp_pkg::*;

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_result    r_s0;
    t_result    r_s1;
    t_result    n_s0;
    t_result    n_s1;
    logic       out_fire;

    assign o_valid    = (r_cnt != 2'd0);
    assign o_res      = r_s0;
    assign out_fire   = o_valid && i_ready;
    // A new pair may land once the last held result leaves in this cycle.
    assign o_can_load = (r_cnt == 2'd0) || (r_cnt == 2'd1 && i_ready);

    always_comb begin
        n_cnt = r_cnt;
        n_s0  = r_s0;
        n_s1  = r_s1;
        if (out_fire) begin
            n_cnt = r_cnt - 2'd1;
            n_s0  = r_s1;
        end
        if (i_load) begin
            n_cnt = i_count;
            n_s0  = i_res0;
            n_s1  = i_res1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s0 <= n_s0;
        r_s1 <= n_s1;
    end

endmodule

// ----- hw/rtl/numeric_field_bcd_hex_packer.sv -----
`timescale 1ns / 1ps

// Streaming packer and unpacker for numeric message fields. Each field opens
// with a byte flagged by i_field_start that also carries the field format
// (copy, left BCD, right BCD, hex, extended left BCD) and its character count.
// With direction 0 ASCII characters are packed into bytes; with direction 1
// packed bytes are expanded into ASCII characters. Every input transfer is
// captured in an input register, decoded against the field state, and its
// zero, one or two results are written into a two-entry result buffer that
// drains one result transfer per cycle while the output is ready. An input
// transfer can be taken every cycle while each item yields at most one result
// and the output is ready; an unpacked byte that expands into two characters
// fills the result buffer, so the next input byte waits until the first has
// left. An input transfer passes through the input register and the result
// buffer before its first result appears. A byte with an invalid format reports
// status 1 and the rest of that field is discarded silently; a byte outside
// any field reports status 2. A write to the direction register closes any
// open field and is accepted only when the input register is empty.
module numeric_field_bcd_hex_packer #(
    parameter int DIGIT_COUNT_BITS = 10
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_direction,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [7:0]                  i_in_byte,
    input  logic                        i_field_start,
    input  logic [2:0]                  i_field_format,
    input  logic [DIGIT_COUNT_BITS-1:0] i_field_digits,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [7:0]                  o_out_byte,
    output logic [1:0]                  o_status,
    output logic                        o_field_end,
    output logic                        o_item_last
);
    import nfbhp_pkg::*;

    localparam int W = DIGIT_COUNT_BITS;

    // Input register.
    logic         r_in_valid;
    logic [7:0]   r_in_byte;
    logic         r_in_start;
    logic [2:0]   r_in_format;
    logic [W-1:0] r_in_digits;

    // Field state.
    logic         r_direction;
    logic [W-1:0] r_chars;
    logic [W-1:0] r_bytes;
    t_flags       r_flags;

    logic [W-1:0] n_chars;
    logic [W-1:0] n_bytes;
    t_flags       n_flags;
    logic [1:0]   core_count;
    t_result      core_res0;
    t_result      core_res1;
    t_result      out_res;
    logic         buf_can_load;
    logic         advance;
    logic         in_fire;
    logic         cfg_fire;

    // The item in the input register moves on once the result buffer can
    // take its results; items that produce nothing still wait for that slot.
    assign advance     = r_in_valid && buf_can_load;
    assign o_in_ready  = !r_in_valid || advance;
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_cfg_ready = !r_in_valid;
    assign cfg_fire    = i_cfg_valid && o_cfg_ready;

    nfbhp_core #(
        .DIGIT_COUNT_BITS(W)
    ) u_core (
        .i_direction (r_direction),
        .i_byte      (r_in_byte),
        .i_start     (r_in_start),
        .i_format    (r_in_format),
        .i_digits    (r_in_digits),
        .i_chars     (r_chars),
        .i_bytes     (r_bytes),
        .i_flags     (r_flags),
        .o_chars     (n_chars),
        .o_bytes     (n_bytes),
        .o_flags     (n_flags),
        .o_count     (core_count),
        .o_res0      (core_res0),
        .o_res1      (core_res1)
    );

    nfbhp_obuf u_obuf (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (advance && core_count != 2'd0),
        .i_count    (core_count),
        .i_res0     (core_res0),
        .i_res1     (core_res1),
        .o_can_load (buf_can_load),
        .o_valid    (o_out_valid),
        .i_ready    (i_out_ready),
        .o_res      (out_res)
    );

    assign o_out_byte  = out_res.data;
    assign o_status    = out_res.status;
    assign o_field_end = out_res.field_end;
    assign o_item_last = out_res.item_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte   <= i_in_byte;
            r_in_start  <= i_field_start;
            r_in_format <= i_field_format;
            r_in_digits <= i_field_digits;
        end
    end

    // A direction write closes the open field; the format code is kept.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_chars     <= '0;
            r_bytes     <= '0;
            r_flags     <= '0;
        end else if (cfg_fire) begin
            r_direction    <= i_cfg_direction;
            r_chars        <= '0;
            r_bytes        <= '0;
            r_flags.active <= 1'b0;
            r_flags.drop   <= 1'b0;
            r_flags.pair   <= 1'b0;
            r_flags.held   <= 8'h00;
        end else if (advance) begin
            r_chars <= n_chars;
            r_bytes <= n_bytes;
            r_flags <= n_flags;
        end
    end

`ifndef ASSERT_OFF
    // A held character only exists inside an open field.
    a_pair_in_field: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_flags.pair |-> r_flags.active)
        else $error("held character outside an open field");

    // Packing never yields more than one result per input byte.
    a_pack_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_direction) |-> (core_count != 2'd2))
        else $error("pack direction produced two results");

    // Error results carry a zero data byte.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_out_byte == 8'h00))
        else $error("error result with nonzero data");

    // A stalled item in the input register keeps its payload.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_byte)))
        else $error("input register lost a stalled item");
`endif

endmodule
